@@ rtl/core/tmon_pkg.sv @@
// shared types and constants for the thermistor temperature monitor
// no dependencies; every other file in rtl/core refers to this package
`default_nettype none
package tmon_pkg;

	// grouping of samples
	localparam int SAMPLES_PER_READING = 5;
	localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
	localparam int SUM_W = $clog2(1023 * SAMPLES_PER_READING + 1);
	localparam int ADC_FULL_SUM = 1023 * SAMPLES_PER_READING;

	// operand widths
	localparam int RES_W = 20;
	localparam int BETA_W = 14;
	localparam int TEMP_W = 13;
	localparam int STATUS_W = 3;
	localparam int LV_W = RES_W + SUM_W;
	localparam int LOG_W = 30;
	localparam int DIVD_W = 60;
	localparam int DIVS_W = 47;
	localparam int DCNT_W = 6;

	// fixed-point constants
	localparam logic [LOG_W-1:0] LN2_Q30 = 30'd744261118;
	localparam logic [DIVS_W-1:0] INV_T0_Q40 =
		47'(((64'd20 << 40) + 64'd2981) / 64'd5963);
	localparam logic [57:0] W_OFFSET =
		58'(64'd5120 * 64'd8192 + 64'd2560 - 64'd87408 * 64'd256);
	localparam logic [57:0] W_SAT = 58'(64'd12288 * 64'd5120);
	localparam logic [TEMP_W-1:0] TEMP_MIN = 13'h1000;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 13'h0FFF;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER_WARN = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVER_WARN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNDER_EMERG = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVER_EMERG = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SERIES = 3'd0;
	localparam logic [2:0] REG_NOMINAL = 3'd1;
	localparam logic [2:0] REG_BETA = 3'd2;
	localparam logic [2:0] REG_OVER_EMERG = 3'd3;
	localparam logic [2:0] REG_OVER_WARN = 3'd4;
	localparam logic [2:0] REG_UNDER_EMERG = 3'd5;
	localparam logic [2:0] REG_UNDER_WARN = 3'd6;

	typedef struct packed {
		logic [RES_W-1:0] series;
		logic [RES_W-1:0] nominal;
		logic [BETA_W-1:0] beta;
		logic signed [TEMP_W-1:0] over_emerg;
		logic signed [TEMP_W-1:0] over_warn;
		logic signed [TEMP_W-1:0] under_emerg;
		logic signed [TEMP_W-1:0] under_warn;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [DCNT_W-1:0] n;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/tmon_front.sv @@
// front end: takes sample beats and sums each group of samples
// depends on tmon_pkg
`default_nettype none
module tmon_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire logic [9:0] sample,
	input wire logic full,
	output logic push,
	output logic [tmon_pkg::SUM_W-1:0] push_data
);
	logic [tmon_pkg::SUM_W-1:0] sum_q;
	logic [tmon_pkg::CNT_W-1:0] count_q;
	logic accept;
	logic last;
	logic [tmon_pkg::SUM_W-1:0] sum_nx;

	// hold off while the queue has no room
	assign sample_stall = full;
	assign accept = sample_valid && !full;
	assign last = (count_q == tmon_pkg::CNT_W'(tmon_pkg::SAMPLES_PER_READING - 1));
	assign sum_nx = sum_q + tmon_pkg::SUM_W'(sample);
	assign push = accept && last;
	assign push_data = sum_nx;

	// group accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= sum_nx;
				count_q <= count_q + tmon_pkg::CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tmon_fifo.sv @@
// two-entry queue of group sums between front and back
// depends on tmon_pkg
`default_nettype none
module tmon_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [tmon_pkg::SUM_W-1:0] push_data,
	input wire logic pop,
	output logic full,
	output logic empty,
	output logic [tmon_pkg::SUM_W-1:0] pop_data
);
	logic [tmon_pkg::SUM_W-1:0] mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tmon_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on tmon_pkg
`default_nettype none
module tmon_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmon_pkg::div_req_t req,
	output tmon_pkg::div_rsp_t rsp
);
	logic [tmon_pkg::DIVS_W-1:0] rem_q;
	logic [tmon_pkg::DIVD_W-1:0] quo_q;
	logic [tmon_pkg::DIVS_W-1:0] divisor_q;
	logic [tmon_pkg::DCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [tmon_pkg::DIVS_W:0] rem_ext;
	logic [tmon_pkg::DIVS_W:0] diff;
	logic ge;
	logic [6:0] pre_shift;

	assign rem_ext = {rem_q, quo_q[tmon_pkg::DIVD_W-1]};
	assign diff = rem_ext - {1'b0, divisor_q};
	assign ge = (rem_ext >= {1'b0, divisor_q});
	assign pre_shift = 7'(tmon_pkg::DIVD_W) - {1'b0, req.n};

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend << pre_shift;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tmon_pkg::DIVS_W-1:0] : rem_ext[tmon_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[tmon_pkg::DIVD_W-2:0], ge};
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - tmon_pkg::DCNT_W'(1);
				if (cnt_q == tmon_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tmon_back.sv @@
// back end: resistance ratio, log2 by squaring, beta equation and status
// depends on tmon_pkg and tmon_div
`default_nettype none
module tmon_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmon_pkg::cfg_t cfg,
	input wire logic empty,
	input wire logic [tmon_pkg::SUM_W-1:0] pop_data,
	output logic pop,
	output logic result_valid,
	input wire logic result_stall,
	output logic signed [tmon_pkg::TEMP_W-1:0] temperature,
	output logic [tmon_pkg::STATUS_W-1:0] status
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NUM = 4'd1;
	localparam logic [3:0] S_DEN = 4'd2;
	localparam logic [3:0] S_NORM = 4'd3;
	localparam logic [3:0] S_SQ = 4'd4;
	localparam logic [3:0] S_LN = 4'd5;
	localparam logic [3:0] S_DIVGO = 4'd6;
	localparam logic [3:0] S_DIVWAIT = 4'd7;
	localparam logic [3:0] S_X = 4'd8;
	localparam logic [3:0] S_W = 4'd9;
	localparam logic [3:0] S_T = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	localparam logic [1:0] OP_Q = 2'd0;
	localparam logic [1:0] OP_RECIP = 2'd1;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [tmon_pkg::SUM_W-1:0] sum_q;
	logic [tmon_pkg::LV_W-1:0] lv_q;
	logic [5:0] p_q;
	logic second_q;
	logic [30:0] m_q;
	logic [23:0] frac_q;
	logic [4:0] it_q;
	logic [tmon_pkg::LOG_W-1:0] lnum_q;
	logic [tmon_pkg::LOG_W-1:0] lden_q;
	logic neg_q;
	logic [tmon_pkg::DIVD_W-1:0] mag_q;
	logic [tmon_pkg::DIVS_W-1:0] x_q;
	logic [25:0] w_q;
	logic [tmon_pkg::DIVD_W-1:0] quot_q;
	logic signed [tmon_pkg::TEMP_W-1:0] t_q;
	logic result_valid_q;
	logic signed [tmon_pkg::TEMP_W-1:0] temperature_q;
	logic [tmon_pkg::STATUS_W-1:0] status_q;

	logic [tmon_pkg::RES_W-1:0] mul_a;
	logic [tmon_pkg::SUM_W-1:0] mul_b;
	logic [tmon_pkg::LV_W-1:0] mul_p;
	logic [61:0] sq;
	logic [31:0] m_nx;
	logic [23:0] frac_nx;
	logic [30:0] m_upd;
	logic [tmon_pkg::LOG_W-1:0] log_nx;
	logic [tmon_pkg::LOG_W-1:0] diff;
	logic [tmon_pkg::DIVD_W-1:0] ln_p;
	logic [tmon_pkg::DIVS_W-1:0] q1;
	logic [57:0] w_nx;
	logic [32:0] q3_p;
	logic [13:0] q3;
	logic [tmon_pkg::STATUS_W-1:0] status_nx;
	tmon_pkg::div_req_t div_req;
	tmon_pkg::div_rsp_t div_rsp;

	tmon_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign pop = (state_q == S_IDLE) && !empty;
	assign result_valid = result_valid_q;
	assign temperature = temperature_q;
	assign status = status_q;

	// shared multiplier for the two resistance products
	assign mul_a = (state_q == S_NUM) ? cfg.series : cfg.nominal;
	assign mul_b = (state_q == S_NUM) ? tmon_pkg::SUM_W'(tmon_pkg::ADC_FULL_SUM) - sum_q : sum_q;
	assign mul_p = {{tmon_pkg::SUM_W{1'b0}}, mul_a} * {{tmon_pkg::RES_W{1'b0}}, mul_b};

	// one squaring step of the log2 fraction
	assign sq = {31'd0, m_q} * {31'd0, m_q};
	assign m_nx = sq[61:30];
	assign m_upd = m_nx[31] ? m_nx[31:1] : m_nx[30:0];
	assign frac_nx = {frac_q[22:0], m_nx[31]};
	assign log_nx = {p_q, frac_nx};

	// ln magnitude in q54
	assign diff = neg_q ? (lden_q - lnum_q) : (lnum_q - lden_q);
	assign ln_p = {30'd0, diff} * {30'd0, tmon_pkg::LN2_Q30};

	assign q1 = quot_q[tmon_pkg::DIVS_W-1:0];
	assign w_nx = {1'b0, quot_q[56:0]} + tmon_pkg::W_OFFSET;

	// w / 5120: drop ten bits, then divide by five through the reciprocal 52429 / 2^18
	assign q3_p = {17'd0, w_q[25:10]} * 33'd52429;
	assign q3 = q3_p[31:18];

	// divider operands by operation
	always_comb begin
		div_req.start = (state_q == S_DIVGO);
		case (op_q)
			OP_Q: begin
				div_req.n = tmon_pkg::DCNT_W'(60);
				div_req.dividend = mag_q;
				div_req.divisor = {19'd0, cfg.beta, 14'd0};
			end
			default: begin
				div_req.n = tmon_pkg::DCNT_W'(57);
				div_req.dividend = 60'd320 << 48;
				div_req.divisor = x_q;
			end
		endcase
	end

	// status ladder
	always_comb begin
		if (t_q >= cfg.over_emerg) begin
			status_nx = tmon_pkg::ST_OVER_EMERG;
		end else if (t_q >= cfg.over_warn) begin
			status_nx = tmon_pkg::ST_OVER_WARN;
		end else if (t_q <= cfg.under_emerg) begin
			status_nx = tmon_pkg::ST_UNDER_EMERG;
		end else if (t_q <= cfg.under_warn) begin
			status_nx = tmon_pkg::ST_UNDER_WARN;
		end else begin
			status_nx = tmon_pkg::ST_OK;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sum_q <= pop_data;
			end
			S_NUM: begin
				lv_q <= mul_p;
				p_q <= 6'(tmon_pkg::LV_W - 1);
				second_q <= 1'b0;
				t_q <= tmon_pkg::TEMP_MIN;
			end
			S_DEN: begin
				lv_q <= mul_p;
				p_q <= 6'(tmon_pkg::LV_W - 1);
				second_q <= 1'b1;
			end
			S_NORM: begin
				if (lv_q[tmon_pkg::LV_W-1]) begin
					m_q <= lv_q[tmon_pkg::LV_W-1 -: 31];
					frac_q <= '0;
					it_q <= '0;
				end else if (lv_q[tmon_pkg::LV_W-1 -: 4] == 4'd0) begin
					lv_q <= lv_q << 4;
					p_q <= p_q - 6'd4;
				end else begin
					lv_q <= lv_q << 1;
					p_q <= p_q - 6'd1;
				end
			end
			S_SQ: begin
				m_q <= m_upd;
				frac_q <= frac_nx;
				it_q <= it_q + 5'd1;
				if (it_q == 5'd23) begin
					if (second_q) begin
						lden_q <= log_nx;
						neg_q <= lnum_q < log_nx;
					end else begin
						lnum_q <= log_nx;
					end
				end
			end
			S_LN: begin
				mag_q <= ln_p;
				op_q <= OP_Q;
			end
			S_DIVGO: begin
			end
			S_DIVWAIT: begin
				if (div_rsp.done) begin
					quot_q <= div_rsp.quotient;
				end
			end
			S_X: begin
				if (neg_q) begin
					if (q1 >= tmon_pkg::INV_T0_Q40) begin
						t_q <= tmon_pkg::TEMP_MIN;
					end
					x_q <= tmon_pkg::INV_T0_Q40 - q1;
				end else begin
					x_q <= tmon_pkg::INV_T0_Q40 + q1;
				end
				op_q <= OP_RECIP;
			end
			S_W: begin
				if (w_nx >= tmon_pkg::W_SAT) begin
					t_q <= tmon_pkg::TEMP_MAX;
				end
				w_q <= w_nx[25:0];
			end
			S_T: begin
				if (q3 < 14'd4096) begin
					t_q <= tmon_pkg::TEMP_MIN;
				end else begin
					t_q <= tmon_pkg::TEMP_W'(q3 - 14'd8192);
				end
			end
			S_DONE: begin
				if (!result_valid_q) begin
					temperature_q <= t_q;
					status_q <= status_nx;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					if (sum_q == '0 || cfg.nominal == '0 || cfg.beta == '0 || mul_p == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_DEN: begin
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (lv_q[tmon_pkg::LV_W-1]) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (it_q == 5'd23) begin
						state_q <= second_q ? S_LN : S_DEN;
					end
				end
				S_LN: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_rsp.done) begin
						case (op_q)
							OP_Q: state_q <= S_X;
							default: state_q <= S_W;
						endcase
					end
				end
				S_X: begin
					if (neg_q && q1 >= tmon_pkg::INV_T0_Q40) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIVGO;
					end
				end
				S_W: begin
					if (w_nx >= tmon_pkg::W_SAT) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_T;
					end
				end
				S_T: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!result_valid_q) begin
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/thermistor_temperature_monitor_core.sv @@
// Thermistor temperature monitor. Sample beats are summed in groups of five; each
// fifth sample yields one result beat with the temperature in signed 1/16 degC and
// a status code. The front takes one sample per cycle and stalls only when the
// two-entry queue of group sums is full. The back computes each reading on its
// own: two log2 evaluations (normalize shifts and 24 squaring steps each), two
// passes through one shared bit-per-cycle divider, a reciprocal multiply for the
// final scaling and setup states; readings that hit a special case finish earlier.
// The user must write configuration registers through the cfg port only while
// idle; the block itself does not enforce this.
// depends on tmon_pkg, tmon_front, tmon_fifo, tmon_back
`default_nettype none
module thermistor_temperature_monitor_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [2:0] cfg_index,
	input wire logic [19:0] cfg_data,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire logic [9:0] sample,
	output logic result_valid,
	input wire logic result_stall,
	output logic signed [12:0] temperature,
	output logic [2:0] status
);
	tmon_pkg::cfg_t cfg_q;
	logic push;
	logic [tmon_pkg::SUM_W-1:0] push_data;
	logic pop;
	logic full;
	logic empty;
	logic [tmon_pkg::SUM_W-1:0] pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.series <= 20'd10000;
			cfg_q.nominal <= 20'd10000;
			cfg_q.beta <= 14'd3950;
			cfg_q.over_emerg <= 13'sd1280;
			cfg_q.over_warn <= 13'sd960;
			cfg_q.under_emerg <= -13'sd320;
			cfg_q.under_warn <= 13'sd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tmon_pkg::REG_SERIES: cfg_q.series <= cfg_data;
				tmon_pkg::REG_NOMINAL: cfg_q.nominal <= cfg_data;
				tmon_pkg::REG_BETA: cfg_q.beta <= cfg_data[13:0];
				tmon_pkg::REG_OVER_EMERG: cfg_q.over_emerg <= cfg_data[12:0];
				tmon_pkg::REG_OVER_WARN: cfg_q.over_warn <= cfg_data[12:0];
				tmon_pkg::REG_UNDER_EMERG: cfg_q.under_emerg <= cfg_data[12:0];
				tmon_pkg::REG_UNDER_WARN: cfg_q.under_warn <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	tmon_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	tmon_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(full),
		.empty(empty),
		.pop_data(pop_data)
	);

	tmon_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.pop_data(pop_data),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.temperature(temperature),
		.status(status)
	);
endmodule
`default_nettype wire

@@ test/tb.sv @@
// self-checking bench for thermistor_temperature_monitor_core: directed table, then random
// groups under several register settings; results are checked against a local predictor
// depends on tmon_pkg and the core rtl
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int GROUP = 5;

	typedef struct {
		logic signed [12:0] temp;
		logic [2:0] stat;
	} reading_t;

	typedef struct {
		logic [9:0] smp;
		bit typed;
		logic signed [12:0] temp;
		logic [2:0] stat;
	} row_t;

	logic clk, arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	logic sample_valid, sample_stall;
	logic [9:0] sample;
	logic result_valid, result_stall;
	logic signed [12:0] temperature;
	logic [2:0] status;

	thermistor_temperature_monitor_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall),
		.temperature(temperature), .status(status)
	);

	// predictor copy of the registers and the group accumulator
	longint unsigned p_series, p_nominal, p_beta;
	int p_over_em, p_over_wr, p_under_em, p_under_wr;
	int acc_sum, acc_cnt;
	reading_t pending_readings[$];
	int errors = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("thermistor_temperature_monitor_core: mismatch");
		$finish;
	end

	// integer log2 in q24 by repeated squaring of a q30 mantissa
	function automatic longint unsigned log2_fix(longint unsigned v);
		int p;
		longint unsigned m, frac;
		p = 63;
		frac = 0;
		while (p > 0 && !v[p]) p--;
		m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(p) << 24) | frac;
	endfunction

	// beta equation on one group sum, saturated to the 13 bit range
	function automatic int temp_of_sum(int sum);
		longint unsigned num, den, ln_n, ln_d, mag, q, x, v, inv_t0;
		longint w;
		bit neg;
		inv_t0 = ((64'd20 << 40) + 64'd2981) / 64'd5963;
		if (sum == 0 || p_nominal == 0 || p_beta == 0) return -4096;
		num = p_series * longint'(1023 * GROUP - sum);
		if (num == 0) return -4096;
		den = longint'(sum) * p_nominal;
		ln_n = log2_fix(num);
		ln_d = log2_fix(den);
		neg = ln_n < ln_d;
		mag = neg ? ln_d - ln_n : ln_n - ln_d;
		mag = mag * 64'd744261118;
		q = mag / (p_beta << 14);
		if (neg) begin
			if (q >= inv_t0) return -4096;
			x = inv_t0 - q;
		end else begin
			x = inv_t0 + q;
		end
		v = (64'd320 << 48) / x;
		w = longint'(v) - 87408 * 256 + 2560 + 5120 * 8192;
		if (w < 0) return -4096;
		w = w / 5120 - 8192;
		if (w < -4096) return -4096;
		if (w > 4095) return 4095;
		return int'(w);
	endfunction

	// accumulate one accepted sample; a full group yields a reading
	function automatic bit take_sample(logic [9:0] s, output reading_t r);
		int t;
		acc_sum += s;
		acc_cnt++;
		if (acc_cnt < GROUP) return 0;
		t = temp_of_sum(acc_sum);
		acc_sum = 0;
		acc_cnt = 0;
		r.temp = 13'(t);
		if (t >= p_over_em) r.stat = tmon_pkg::ST_OVER_EMERG;
		else if (t >= p_over_wr) r.stat = tmon_pkg::ST_OVER_WARN;
		else if (t <= p_under_em) r.stat = tmon_pkg::ST_UNDER_EMERG;
		else if (t <= p_under_wr) r.stat = tmon_pkg::ST_UNDER_WARN;
		else r.stat = tmon_pkg::ST_OK;
		return 1;
	endfunction

	function automatic int sext13(logic [19:0] d);
		return int'(signed'(d[12:0]));
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [19:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			tmon_pkg::REG_SERIES: p_series = d;
			tmon_pkg::REG_NOMINAL: p_nominal = d;
			tmon_pkg::REG_BETA: p_beta = d[13:0];
			tmon_pkg::REG_OVER_EMERG: p_over_em = sext13(d);
			tmon_pkg::REG_OVER_WARN: p_over_wr = sext13(d);
			tmon_pkg::REG_UNDER_EMERG: p_under_em = sext13(d);
			tmon_pkg::REG_UNDER_WARN: p_under_wr = sext13(d);
			default: ;
		endcase
	endtask

	// present one sample beat and wait for it to be taken
	task automatic send_beat(logic [9:0] s, bit typed, reading_t given);
		reading_t r;
		bit taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do begin
			@(posedge clk);
			taken = !sample_stall;
		end while (!taken);
		if (take_sample(s, r)) pending_readings.push_back(typed ? given : r);
	endtask

	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [9:0] pick_sample();
		case ($urandom_range(3))
			0: return 10'($urandom_range(15));
			1: return 10'($urandom_range(1023, 1008));
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	// receiver back-pressure
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_idle_pct);

	// result check against the oldest expected reading
	always @(posedge clk) begin
		reading_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result temperature %0d status %0d",
					$time, temperature, status);
				errors++;
			end else begin
				e = pending_readings.pop_front();
				if (temperature !== e.temp) begin
					$display("%0t: temperature expected %0d actual %0d",
						$time, e.temp, temperature);
					errors++;
				end
				if (status !== e.stat) begin
					$display("%0t: status expected %0d actual %0d",
						$time, e.stat, status);
					errors++;
				end
			end
		end
	end

	row_t dir_rows[25];
	reading_t none;

	initial begin
		cfg_write = 0;
		cfg_index = tmon_pkg::REG_SERIES;
		cfg_data = 0;
		sample_valid = 0;
		sample = 0;
		result_stall = 0;
		p_series = 10000;
		p_nominal = 10000;
		p_beta = 3950;
		p_over_em = 1280;
		p_over_wr = 960;
		p_under_em = -320;
		p_under_wr = 0;
		acc_sum = 0;
		acc_cnt = 0;
		none = '{temp: 0, stat: tmon_pkg::ST_OK};

		// directed rows: zero sum, full scale, then predicted groups
		for (int i = 0; i < 25; i++) begin
			dir_rows[i] = '{smp: 0, typed: 0, temp: 0, stat: tmon_pkg::ST_OK};
			if (i < 5) dir_rows[i] = '{0, 1, -13'sd4096, tmon_pkg::ST_UNDER_EMERG};
			else if (i < 10)
				dir_rows[i] = '{10'd1023, 1, -13'sd4096, tmon_pkg::ST_UNDER_EMERG};
			else if (i < 15) dir_rows[i].smp = 10'd512;
			else if (i < 20) dir_rows[i].smp = 10'd1 << (i - 15);
			else dir_rows[i].smp = 10'd32 << (i - 20);
		end

		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_idle_pct = 32;
		recv_idle_pct = 54;
		foreach (dir_rows[i])
			send_beat(dir_rows[i].smp, dir_rows[i].typed,
				'{temp: dir_rows[i].temp, stat: dir_rows[i].stat});
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 32;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: begin
					write_reg(tmon_pkg::REG_SERIES, 20'd1);
					write_reg(tmon_pkg::REG_NOMINAL, 20'd1000000);
					write_reg(tmon_pkg::REG_BETA, 20'd1);
					write_reg(tmon_pkg::REG_OVER_EMERG, 20'h00FFF);
					write_reg(tmon_pkg::REG_OVER_WARN, 20'h00FFF);
					write_reg(tmon_pkg::REG_UNDER_EMERG, 20'h01000);
					write_reg(tmon_pkg::REG_UNDER_WARN, 20'h01000);
				end
				1: begin
					write_reg(tmon_pkg::REG_SERIES, 20'd1000000);
					write_reg(tmon_pkg::REG_NOMINAL, 20'd1);
					write_reg(tmon_pkg::REG_BETA, 20'd10000);
					write_reg(REG_UNUSED, 20'hFFFFF);
				end
				2: begin
					write_reg(tmon_pkg::REG_SERIES, 20'd0);
					write_reg(tmon_pkg::REG_NOMINAL, 20'd0);
					write_reg(tmon_pkg::REG_BETA, 20'hFFFFF);
				end
				3: begin
					// back to nominal parts with tight limits around room temperature
					write_reg(tmon_pkg::REG_SERIES, 20'd10000);
					write_reg(tmon_pkg::REG_NOMINAL, 20'd10000);
					write_reg(tmon_pkg::REG_BETA, 20'd3950);
					write_reg(tmon_pkg::REG_OVER_EMERG, 20'd600);
					write_reg(tmon_pkg::REG_OVER_WARN, 20'd420);
					write_reg(tmon_pkg::REG_UNDER_EMERG, 20'd200);
					write_reg(tmon_pkg::REG_UNDER_WARN, 20'd380);
				end
				default: begin
					for (int r = 0; r < 7; r++) begin
						logic [19:0] d;
						d = 20'($urandom);
						if (r <= 1 && $urandom_range(1)) d = 20'($urandom_range(1000000, 1));
						if (r == 2 && $urandom_range(1)) d = 20'($urandom_range(10000, 1));
						write_reg(3'(r), d);
					end
				end
			endcase
			for (int k = 0; k < 75; k++) send_beat(pick_sample(), 0, none);
			drain();
		end

		if (errors == 0)
			$display("thermistor_temperature_monitor_core: match");
		else
			$display("thermistor_temperature_monitor_core: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
